@@ hdl/tga_rle_pixel_decoder_unit_assert.svh @@
// assertion macros for the tga rle pixel decoder
// expects clk and rst_n in the scope where a macro is used
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TGA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tga rle decoder: implication failed");

// next-cycle implication
`define TGA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tga rle decoder: next-cycle implication failed");

`else

`define TGA_ASSERT_IMPLY(lbl, ante, cons)
`define TGA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hdl/tga_rle_pkg.sv @@
// shared types, constants and helpers for the tga rle pixel decoder
// no dependencies
package tga_rle_pkg;

    localparam int BYTE_W       = 8;
    localparam int PB_W         = 3;
    localparam int POS_W        = 2;
    localparam int CFG_DATA_W   = 3;
    localparam int CFG_INDEX_W  = 2;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] OPAQUE_ALPHA = 8'd255;
    localparam logic [BYTE_W-1:0] COUNT_MASK   = 8'h7f;
    localparam logic [BYTE_W-1:0] RUN_FLAG     = 8'h80;

    localparam logic [PB_W-1:0] PB_RESET  = 3'd4;
    localparam logic            RLE_RESET = 1'b1;

    // register indexes on the write port
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RLE_ENABLED = 2'd1;

    typedef enum logic [1:0] {
        FMT_GREY,
        FMT_BGR,
        FMT_BGRA
    } pixel_fmt_t;

    // one non-header byte handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              last;
        logic [BYTE_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic [BYTE_W-1:0] count;
    } pixel_t;

    // unsupported sizes decode as grey
    function automatic pixel_fmt_t pixel_format(input logic [PB_W-1:0] pb);
        pixel_fmt_t fmt;
        case (pb)
            3'd3:    fmt = FMT_BGR;
            3'd4:    fmt = FMT_BGRA;
            default: fmt = FMT_GREY;
        endcase
        return fmt;
    endfunction

    // position of the final byte of a pixel
    function automatic logic [POS_W-1:0] last_pos(input pixel_fmt_t fmt);
        logic [POS_W-1:0] p;
        case (fmt)
            FMT_BGR:  p = 2'd2;
            FMT_BGRA: p = 2'd3;
            default:  p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

@@ hdl/tga_rle_pixel_decoder_unit.sv @@
// TGA run-length pixel decoder, one payload byte per cycle in, RGBA8888 pixels with a
// repeat count out. The front part parses packet headers and tags every pixel byte; a
// four-entry queue carries the tagged bytes to the back part, which gathers them and
// holds the finished pixel in an output register. Bytes are taken every cycle unless the
// queue is full; a pixel shows on the result ports at the edge where its last byte leaves
// the queue, and header bytes give no result. Pixel rate is set by the byte stream: one
// pixel per 1, 3 or 4 bytes. Writing either register restarts packet and pixel parsing.
// depends on tga_rle_pkg, tga_rle_front, tga_rle_queue, tga_rle_back and the assert header
`include "tga_rle_pixel_decoder_unit_assert.svh"

module tga_rle_pixel_decoder_unit
    import tga_rle_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    input  logic                   push,
    output logic                   full,
    input  logic [BYTE_W-1:0]      data_byte,
    output logic                   empty,
    input  logic                   pop,
    output logic [BYTE_W-1:0]      red,
    output logic [BYTE_W-1:0]      green,
    output logic [BYTE_W-1:0]      blue,
    output logic [BYTE_W-1:0]      alpha,
    output logic [BYTE_W-1:0]      repeat_count
);

    logic [PB_W-1:0] pixel_bytes_reg, pixel_bytes_next;
    logic            rle_enabled_reg, rle_enabled_next;
    logic            clear;
    logic            accept;
    logic            q_push, q_pop, q_full, q_empty;
    entry_t          q_wr_entry, q_rd_entry;
    pixel_t          pixel;

    always_comb
    begin
        pixel_bytes_next = pixel_bytes_reg;
        rle_enabled_next = rle_enabled_reg;
        clear            = 1'b0;
        if (wr_en)
        begin
            case (wr_index)
                REG_PIXEL_BYTES:
                begin
                    pixel_bytes_next = wr_data;
                    clear            = 1'b1;
                end
                REG_RLE_ENABLED:
                begin
                    rle_enabled_next = wr_data[0];
                    clear            = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bytes_reg <= PB_RESET;
            rle_enabled_reg <= RLE_RESET;
        end
        else
        begin
            pixel_bytes_reg <= pixel_bytes_next;
            rle_enabled_reg <= rle_enabled_next;
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    tga_rle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .pixel_bytes (pixel_bytes_reg),
        .rle_enabled (rle_enabled_reg),
        .clear       (clear),
        .entry_push  (q_push),
        .entry       (q_wr_entry)
    );

    tga_rle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_push),
        .wr_entry (q_wr_entry),
        .rd       (q_pop),
        .rd_entry (q_rd_entry),
        .full     (q_full),
        .empty    (q_empty)
    );

    tga_rle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_bytes (pixel_bytes_reg),
        .q_empty     (q_empty),
        .q_entry     (q_rd_entry),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .pixel       (pixel)
    );

    assign red          = pixel.red;
    assign green        = pixel.green;
    assign blue         = pixel.blue;
    assign alpha        = pixel.alpha;
    assign repeat_count = pixel.count;

    // a transaction into the queue never lands on a full queue
    `TGA_ASSERT_IMPLY(a_no_overflow, q_push, !q_full)
    // the back part never reads an empty queue
    `TGA_ASSERT_IMPLY(a_no_underflow, q_pop, !q_empty)
    // a held pixel always carries a real count
    `TGA_ASSERT_IMPLY(a_count_nonzero, !empty, repeat_count != '0)

endmodule

@@ hdl/tga_rle_front.sv @@
// front part: packet header parsing and byte classification
// depends on tga_rle_pkg
module tga_rle_front
    import tga_rle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [PB_W-1:0]   pixel_bytes,
    input  logic              rle_enabled,
    input  logic              clear,
    output logic              entry_push,
    output entry_t            entry
);

    logic [BYTE_W-1:0] rem_reg, rem_next;
    logic              run_reg, run_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    pixel_fmt_t fmt;
    logic       is_header;
    logic       is_last;

    assign fmt       = pixel_format(pixel_bytes);
    assign is_header = rle_enabled && (rem_reg == '0);
    assign is_last   = (pos_reg >= last_pos(fmt));

    always_comb
    begin
        rem_next   = rem_reg;
        run_next   = run_reg;
        pos_next   = pos_reg;
        entry_push = 1'b0;
        entry.data  = data_byte;
        entry.pos   = pos_reg;
        entry.last  = is_last;
        entry.count = (rle_enabled && run_reg) ? rem_reg : 8'd1;
        if (clear)
        begin
            rem_next = '0;
            run_next = 1'b0;
            pos_next = '0;
        end
        else if (accept)
        begin
            if (is_header)
            begin
                rem_next = (data_byte & COUNT_MASK) + 8'd1;
                run_next = ((data_byte & RUN_FLAG) != '0);
                pos_next = '0;
            end
            else
            begin
                entry_push = 1'b1;
                if (!is_last)
                begin
                    pos_next = pos_reg + 2'd1;
                end
                else
                begin
                    pos_next = '0;
                    if (rle_enabled)
                    begin
                        rem_next = run_reg ? 8'd0 : rem_reg - 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            run_reg <= 1'b0;
            pos_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            run_reg <= run_next;
            pos_reg <= pos_next;
        end
    end

endmodule

@@ hdl/tga_rle_queue.sv @@
// short register queue between front and back parts
// depends on tga_rle_pkg
module tga_rle_queue
    import tga_rle_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr,
    input  entry_t wr_entry,
    input  logic   rd,
    output entry_t rd_entry,
    output logic   full,
    output logic   empty
);

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

@@ hdl/tga_rle_back.sv @@
// back part: gathers pixel bytes, expands to rgba and holds the result
// depends on tga_rle_pkg
module tga_rle_back
    import tga_rle_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [PB_W-1:0] pixel_bytes,
    input  logic            q_empty,
    input  entry_t          q_entry,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output pixel_t          pixel
);

    logic [BYTE_W-1:0] held0_reg, held1_reg, held2_reg;
    logic              out_valid_reg, out_valid_next;
    pixel_t            out_pix_reg, out_pix_next;
    logic              out_free;
    logic              emit;

    assign out_free = !out_valid_reg || pop;
    assign q_pop    = !q_empty && (!q_entry.last || out_free);
    assign emit     = q_pop && q_entry.last;
    assign empty    = !out_valid_reg;
    assign pixel    = out_pix_reg;

    always_comb
    begin
        out_pix_next       = out_pix_reg;
        out_pix_next.count = q_entry.count;
        case (pixel_format(pixel_bytes))
            FMT_BGR:
            begin
                out_pix_next.blue  = held0_reg;
                out_pix_next.green = held1_reg;
                out_pix_next.red   = q_entry.data;
                out_pix_next.alpha = OPAQUE_ALPHA;
            end
            FMT_BGRA:
            begin
                out_pix_next.blue  = held0_reg;
                out_pix_next.green = held1_reg;
                out_pix_next.red   = held2_reg;
                out_pix_next.alpha = q_entry.data;
            end
            default:
            begin
                out_pix_next.blue  = q_entry.data;
                out_pix_next.green = q_entry.data;
                out_pix_next.red   = q_entry.data;
                out_pix_next.alpha = OPAQUE_ALPHA;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_pix_reg <= out_pix_next;
        end
        if (q_pop && !q_entry.last)
        begin
            case (q_entry.pos)
                2'd0:    held0_reg <= q_entry.data;
                2'd1:    held1_reg <= q_entry.data;
                2'd2:    held2_reg <= q_entry.data;
                default: ;
            endcase
        end
    end

endmodule

@@ verif/tga_rle_pixel_decoder_unit_checker.sv @@
`timescale 1ns / 100ps
// pixel checker for the tga rle decoder: watches the register port, the byte input and the pixel output,
// predicts each decoded pixel and compares it with what the block hands out
// depends on tga_rle_pkg
module tga_rle_pixel_decoder_unit_checker
    import tga_rle_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    input  logic                   push,
    input  logic                   full,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic                   empty,
    input  logic                   pop,
    input  logic [BYTE_W-1:0]      red,
    input  logic [BYTE_W-1:0]      green,
    input  logic [BYTE_W-1:0]      blue,
    input  logic [BYTE_W-1:0]      alpha,
    input  logic [BYTE_W-1:0]      repeat_count,
    output int                     errors,
    output int                     pending
);

    logic [PB_W-1:0]   pb_cfg;
    logic              rle_cfg;
    logic [BYTE_W-1:0] pkt_left;
    logic              in_run;
    logic [POS_W-1:0]  byte_idx;
    logic [BYTE_W-1:0] held [3];
    pixel_t            pixel_q [$];

    task automatic report(input string msg);
        $display("%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] got,
                               input logic [BYTE_W-1:0] want);
        if (got !== want)
            report($sformatf("%s mismatch: got %0d expected %0d", name, got, want));
    endtask

    task automatic restart_parse();
        pkt_left = '0;
        in_run   = 1'b0;
        byte_idx = '0;
    endtask

    // one payload byte in, zero or one decoded pixel queued
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        int     sz;
        pixel_t px;
        sz = (pb_cfg == 3'd3 || pb_cfg == 3'd4) ? int'(pb_cfg) : 1;
        if (rle_cfg && pkt_left == 0) begin
            pkt_left = (b & COUNT_MASK) + 8'd1;
            in_run   = (b & RUN_FLAG) != 0;
            byte_idx = '0;
            return;
        end
        if (int'(byte_idx) + 1 < sz) begin
            held[byte_idx] = b;
            byte_idx = byte_idx + 2'd1;
            return;
        end
        case (sz)
            3: begin
                px.blue  = held[0];
                px.green = held[1];
                px.red   = b;
                px.alpha = OPAQUE_ALPHA;
            end
            4: begin
                px.blue  = held[0];
                px.green = held[1];
                px.red   = held[2];
                px.alpha = b;
            end
            default: begin
                px.red   = b;
                px.green = b;
                px.blue  = b;
                px.alpha = OPAQUE_ALPHA;
            end
        endcase
        byte_idx = '0;
        px.count = 8'd1;
        if (rle_cfg) begin
            if (in_run) begin
                px.count = pkt_left;
                pkt_left = '0;
            end
            else begin
                pkt_left = pkt_left - 8'd1;
            end
        end
        pixel_q.push_back(px);
    endtask

    always @(posedge clk) begin
        pixel_t want;
        if (!rst_n) begin
            pb_cfg  = PB_RESET;
            rle_cfg = RLE_RESET;
            errors  = 0;
            restart_parse();
            pixel_q.delete();
        end
        else begin
            // compare before predicting so a result can never match its own input
            if (pop && !empty) begin
                if (pixel_q.size() == 0) begin
                    report($sformatf("unexpected pixel r=%0d g=%0d b=%0d a=%0d n=%0d",
                                     red, green, blue, alpha, repeat_count));
                end
                else begin
                    want = pixel_q.pop_front();
                    check_field("red", red, want.red);
                    check_field("green", green, want.green);
                    check_field("blue", blue, want.blue);
                    check_field("alpha", alpha, want.alpha);
                    check_field("repeat_count", repeat_count, want.count);
                end
            end
            if (wr_en) begin
                case (wr_index)
                    REG_PIXEL_BYTES: begin
                        pb_cfg = wr_data[PB_W-1:0];
                        restart_parse();
                    end
                    REG_RLE_ENABLED: begin
                        rle_cfg = wr_data[0];
                        restart_parse();
                    end
                    default: ;
                endcase
            end
            if (push && !full)
                decode_byte(data_byte);
        end
        pending = pixel_q.size();
    end

endmodule

@@ verif/tga_rle_pixel_decoder_unit_tb.sv @@
`timescale 1ns / 100ps
// top of the tga rle decoder testbench: clock, reset, byte stream and register writes
// depends on tga_rle_pkg, the decoder rtl and tga_rle_pixel_decoder_unit_checker
module tga_rle_pixel_decoder_unit_tb;
    import tga_rle_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_LAT   = 12;
    localparam int PHASES       = 12;

    // indexes past the register list, writes there are ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] wr_index = '0;
    logic [CFG_DATA_W-1:0]  wr_data = '0;
    logic                   push = 1'b0;
    logic                   full;
    logic [BYTE_W-1:0]      data_byte = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [BYTE_W-1:0]      red, green, blue, alpha, repeat_count;
    int                     errors;
    int                     pending;

    int          cycle_cnt = 0;
    int          sent = 0;
    int          burst_left = 0;
    logic [1:0]  stall_mode = 2'd0;
    int          stall_cnt = 0;

    // pixel size and mode the stream is shaped for
    int          pix_size = 4;
    logic        rle_on = 1'b1;

    tga_rle_pixel_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .empty        (empty),
        .pop          (pop),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .repeat_count (repeat_count)
    );

    tga_rle_pixel_decoder_unit_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .empty        (empty),
        .pop          (pop),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .repeat_count (repeat_count),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tga_rle_pixel_decoder_unit test failed");
            $finish;
        end
    end

    // pixel sink: each mode holds for a random stretch
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (stall_cnt == 0)
            begin
                stall_mode <= 2'($urandom_range(0, 3));
                stall_cnt  <= $urandom_range(20, 120);
            end
            else
            begin
                stall_cnt <= stall_cnt - 1;
            end
            case (stall_mode)
                2'd0:    pop <= 1'b1;
                2'd1:    pop <= 1'($urandom_range(0, 1));
                2'd2:    pop <= ($urandom_range(0, 3) == 0);
                default: pop <= (stall_cnt % 8) < 5;
            endcase
        end
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // one byte transaction; push stays high inside a burst
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        push      <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (full);
        sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_bytes(input logic [63:0] w, input int n);
        for (int i = n - 1; i >= 0; i--)
            send_byte(w[8*i +: 8]);
    endtask

    // registers only change once every pixel is out and the byte queue has drained
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_LAT) @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_PIXEL_BYTES)
            pix_size = (val == 3'd3 || val == 3'd4) ? int'(val) : 1;
        else if (idx == REG_RLE_ENABLED)
            rle_on = val[0];
    endtask

    // mostly well-formed packets with random content, some odd headers and slips
    task automatic random_stream(input int n);
        int                stop;
        int                body_left;
        int                cnt;
        logic [BYTE_W-1:0] hdr;
        stop = sent + n;
        body_left = 0;
        while (sent < stop)
        begin
            if (rle_on && body_left == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    hdr = 8'($urandom);
                end
                else
                begin
                    cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(0, 7);
                    hdr = {1'($urandom_range(0, 1)), 7'(cnt)};
                end
                send_byte(hdr);
                body_left = (hdr[7] ? 1 : int'(hdr[6:0]) + 1) * pix_size;
            end
            else
            begin
                send_byte(rand_byte());
                // an occasional slip leaves the shaping out of step with the packets
                if (body_left > 0 && $urandom_range(0, 19) != 0)
                    body_left--;
            end
        end
    endtask

    initial
    begin
        logic [PB_W-1:0] pb_plan [PHASES] = '{3'd4, 3'd3, 3'd1, 3'd0, 3'd7, 3'd2,
                                              3'd5, 3'd6, 3'd3, 3'd4, 3'd1, 3'd4};
        logic            rle_plan [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                                               1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: bgra run of the largest count, then a raw packet
        send_bytes(64'hff_00_ff_00_ff, 5);
        send_bytes(64'h01_10_20_30_40, 5);
        send_bytes(64'h50_60, 2);
        // writes past the register list must not disturb the pixel in progress
        write_reg(REG_SPARE_LO, 3'd7);
        write_reg(REG_SPARE_HI, 3'd0);
        send_bytes(64'h70_80, 2);

        write_reg(REG_PIXEL_BYTES, 3'd3);
        send_bytes(64'h81_aa_55_01, 4);
        // packet cut short by a register write
        send_bytes(64'h02_33_44, 3);
        write_reg(REG_RLE_ENABLED, 1'b0);
        send_bytes(64'hc0_de_7f, 3);
        // unsupported size decodes as grey
        write_reg(REG_PIXEL_BYTES, 3'd0);
        send_bytes(64'h00_ff, 2);

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_PIXEL_BYTES, pb_plan[p]);
            write_reg(REG_RLE_ENABLED, rle_plan[p]);
            random_stream($urandom_range(52, 72));
            // sometimes a spare write lands mid-packet, then the stream carries on
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          3'($urandom));
                random_stream($urandom_range(10, 30));
            end
        end

        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tga_rle_pixel_decoder_unit test passed");
        else
            $display("tga_rle_pixel_decoder_unit test failed");
        $finish;
    end

endmodule
